FILE: rtl/core/hltd_pkg.sv
// Package for the header/length/trailer deframer.
// Holds shared types, codes and defaults; used by hltd_ctrl, hltd_dp and the top level.
package hltd_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int MAX_PAYLOAD_DEF  = 32;

  localparam logic [15:0] HEAD_MARK_RST = 16'hA55A;
  localparam logic [15:0] END_MARK_RST  = 16'h5AA5;
  localparam logic [5:0]  MAX_LEN_RST   = 6'd32;

  localparam logic [1:0] REG_HEAD_MARK = 2'd0;
  localparam logic [1:0] REG_END_MARK  = 2'd1;
  localparam logic [1:0] REG_MAX_LEN   = 2'd2;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_TYPE,
    PH_LEN,
    PH_END
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DROP,
    S_CHECK,
    S_H0,
    S_H1,
    S_T,
    S_L,
    S_E0,
    S_E1,
    S_EMPTY,
    S_P_RD,
    S_P_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    RD_OLD0,
    RD_OLD1,
    RD_SCAN,
    RD_END0,
    RD_END1,
    RD_PAY
  } rd_sel_t;

  typedef enum logic [1:0] {
    EM_DROP,
    EM_EMPTY,
    EM_DATA
  } emit_t;

  typedef struct packed {
    logic    take;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_b0;
    logic    set_type;
    logic    set_len;
    logic    adv_scan;
    logic    start_scan2;
    logic    discard1;
    logic    discard_frame;
    logic    clr_idx;
    logic    adv_idx;
    logic    emit;
    emit_t   emit_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic avail_ge1;
    logic avail_ge2;
    logic avail_end;
    logic head_hit;
    logic end_hit;
    logic len_bad;
    logic len_zero;
    logic idx_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/hltd_ctrl.sv
// Sequencer of the deframer: parse phase and step state machine.
// Depends on hltd_pkg; drives hltd_dp through dp_cmd_t and reads dp_stat_t.
module hltd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hltd_pkg::dp_stat_t stat,
  output hltd_pkg::dp_cmd_t  cmd
);
  import hltd_pkg::*;

  ctl_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_HEAD;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // next state and parse phase
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = stat.full ? S_DROP : S_CHECK;
      end
      S_DROP: begin
        if (stat.out_free) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        unique case (phase_r)
          PH_HEAD: state_nxt = stat.avail_ge2 ? S_H0 : S_IDLE;
          PH_TYPE: state_nxt = stat.avail_ge1 ? S_T : S_IDLE;
          PH_LEN:  state_nxt = stat.avail_ge1 ? S_L : S_IDLE;
          PH_END:  state_nxt = stat.avail_end ? S_E0 : S_IDLE;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_H0: state_nxt = S_H1;
      S_H1: begin
        state_nxt = S_CHECK;
        if (stat.head_hit) phase_nxt = PH_TYPE;
      end
      S_T: begin
        state_nxt = S_CHECK;
        phase_nxt = PH_LEN;
      end
      S_L: begin
        state_nxt = S_CHECK;
        phase_nxt = stat.len_bad ? PH_HEAD : PH_END;
      end
      S_E0: state_nxt = S_E1;
      S_E1: begin
        if (!stat.end_hit) begin
          state_nxt = S_CHECK;
          phase_nxt = PH_HEAD;
        end else if (stat.len_zero) begin
          state_nxt = S_EMPTY;
        end else begin
          state_nxt = S_P_RD;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          state_nxt = S_CHECK;
          phase_nxt = PH_HEAD;
        end
      end
      S_P_RD: state_nxt = S_P_OUT;
      S_P_OUT: begin
        if (stat.out_free) begin
          if (stat.idx_last) begin
            state_nxt = S_CHECK;
            phase_nxt = PH_HEAD;
          end else begin
            state_nxt = S_P_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = RD_SCAN;
    cmd.emit_kind = EM_DATA;
    in_stall      = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: cmd.take = in_valid;
      S_DROP: begin
        cmd.emit      = stat.out_free;
        cmd.emit_kind = EM_DROP;
      end
      S_CHECK: begin
        cmd.rd_en = 1'b1;
        unique case (phase_r)
          PH_HEAD: cmd.rd_sel = RD_OLD0;
          PH_TYPE: cmd.rd_sel = RD_SCAN;
          PH_LEN:  cmd.rd_sel = RD_SCAN;
          PH_END:  cmd.rd_sel = RD_END0;
          default: cmd.rd_sel = RD_SCAN;
        endcase
      end
      S_H0: begin
        cmd.cap_b0 = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_OLD1;
      end
      S_H1: begin
        cmd.start_scan2 = stat.head_hit;
        cmd.discard1    = !stat.head_hit;
      end
      S_T: begin
        cmd.set_type = 1'b1;
        cmd.adv_scan = 1'b1;
      end
      S_L: begin
        cmd.discard1 = stat.len_bad;
        cmd.set_len  = !stat.len_bad;
        cmd.adv_scan = !stat.len_bad;
      end
      S_E0: begin
        cmd.cap_b0 = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_END1;
      end
      S_E1: begin
        cmd.discard1 = !stat.end_hit;
        cmd.clr_idx  = stat.end_hit;
      end
      S_EMPTY: begin
        cmd.emit          = stat.out_free;
        cmd.emit_kind     = EM_EMPTY;
        cmd.discard_frame = stat.out_free;
      end
      S_P_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PAY;
      end
      S_P_OUT: begin
        cmd.emit          = stat.out_free;
        cmd.emit_kind     = EM_DATA;
        cmd.discard_frame = stat.out_free && stat.idx_last;
        cmd.adv_idx       = stat.out_free && !stat.idx_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/hltd_dp.sv
// Datapath of the deframer: byte ring, pointers, config registers, output register.
// Depends on hltd_pkg; commanded by hltd_ctrl.
module hltd_dp #(
  parameter int BUFFER_DEPTH = hltd_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_PAYLOAD  = hltd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hltd_pkg::dp_cmd_t  cmd,
  output hltd_pkg::dp_stat_t stat,
  input  logic [7:0]         in_rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_msg_type,
  output logic [7:0]         out_data_byte,
  output logic               out_data_valid,
  output logic               out_frame_last,
  output logic               out_byte_dropped
);
  import hltd_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int EW = CW + 9;
  localparam logic [PW:0] DEPTH_W = (PW+1)'(BUFFER_DEPTH);
  localparam int CAP_I = (MAX_PAYLOAD < BUFFER_DEPTH - 6) ? MAX_PAYLOAD : BUFFER_DEPTH - 6;
  localparam logic [7:0] CAP = 8'(CAP_I);

  function automatic logic [PW-1:0] wrap(input logic [PW:0] s);
    return (s >= DEPTH_W) ? PW'(s - DEPTH_W) : s[PW-1:0];
  endfunction

  logic [7:0]    ring [BUFFER_DEPTH];
  logic [7:0]    rd_data_r, byte0_r, type_r, len_r, idx_r;
  logic [PW-1:0] oldest_r, scan_r, rd_addr, wr_addr, oldest_new;
  logic [CW-1:0] held_r, off_r, avail, drop_n;
  logic [15:0]   head_r, end_r;
  logic [5:0]    maxlen_r;
  logic [7:0]    limit;
  logic          out_valid_r;
  logic [7:0]    msg_type_r, data_byte_r;
  logic          data_valid_r, frame_last_r, byte_dropped_r;

  // configuration: always ready; the user must make writes only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= HEAD_MARK_RST;
      end_r    <= END_MARK_RST;
      maxlen_r <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEAD_MARK: head_r   <= cfg_data;
        REG_END_MARK:  end_r    <= cfg_data;
        REG_MAX_LEN:   maxlen_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign limit = ({2'b00, maxlen_r} > CAP) ? CAP : {2'b00, maxlen_r};

  always_comb begin
    case (cmd.rd_sel)
      RD_OLD0: rd_addr = oldest_r;
      RD_OLD1: rd_addr = wrap({1'b0, oldest_r} + (PW+1)'(1));
      RD_END0: rd_addr = wrap({1'b0, scan_r} + (PW+1)'(len_r));
      RD_END1: rd_addr = wrap({1'b0, scan_r} + (PW+1)'(len_r) + (PW+1)'(1));
      RD_PAY:  rd_addr = wrap({1'b0, scan_r} + (PW+1)'(idx_r));
      default: rd_addr = scan_r;
    endcase
  end

  assign wr_addr    = wrap({1'b0, oldest_r} + (PW+1)'(held_r));
  assign drop_n     = cmd.discard_frame ? (off_r + CW'(len_r) + CW'(2)) : CW'(1);
  assign oldest_new = wrap({1'b0, oldest_r} + (PW+1)'(drop_n));

  // ring memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.take && !stat.full) ring[wr_addr] <= in_rx_byte;
    if (cmd.rd_en) rd_data_r <= ring[rd_addr];
    if (cmd.cap_b0) byte0_r <= rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      scan_r   <= '0;
      held_r   <= '0;
      off_r    <= '0;
      type_r   <= '0;
      len_r    <= '0;
      idx_r    <= '0;
    end else begin
      if (cmd.take && !stat.full) held_r <= held_r + CW'(1);
      if (cmd.set_type) type_r <= rd_data_r;
      if (cmd.set_len) len_r <= rd_data_r;
      if (cmd.clr_idx) idx_r <= '0;
      if (cmd.adv_idx) idx_r <= idx_r + 8'd1;
      if (cmd.adv_scan) begin
        scan_r <= wrap({1'b0, scan_r} + (PW+1)'(1));
        off_r  <= off_r + CW'(1);
      end
      if (cmd.start_scan2) begin
        scan_r <= wrap({1'b0, oldest_r} + (PW+1)'(2));
        off_r  <= CW'(2);
      end
      if (cmd.discard1 || cmd.discard_frame) begin
        oldest_r <= oldest_new;
        scan_r   <= oldest_new;
        held_r   <= held_r - drop_n;
        off_r    <= '0;
      end
    end
  end

  assign avail          = held_r - off_r;
  assign stat.full      = (held_r == CW'(BUFFER_DEPTH));
  assign stat.avail_ge1 = (avail != '0);
  assign stat.avail_ge2 = (avail >= CW'(2));
  assign stat.avail_end = (EW'(avail) >= EW'(len_r) + EW'(2));
  assign stat.head_hit  = (byte0_r == head_r[15:8]) && (rd_data_r == head_r[7:0]);
  assign stat.end_hit   = (byte0_r == end_r[15:8]) && (rd_data_r == end_r[7:0]);
  assign stat.len_bad   = (rd_data_r > limit);
  assign stat.len_zero  = (len_r == 8'd0);
  assign stat.idx_last  = ({1'b0, idx_r} + 9'd1 == {1'b0, len_r});
  assign stat.out_free  = !out_valid_r || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_kind)
        EM_DROP: begin
          msg_type_r     <= 8'd0;
          data_byte_r    <= 8'd0;
          data_valid_r   <= 1'b0;
          frame_last_r   <= 1'b0;
          byte_dropped_r <= 1'b1;
        end
        EM_EMPTY: begin
          msg_type_r     <= type_r;
          data_byte_r    <= 8'd0;
          data_valid_r   <= 1'b0;
          frame_last_r   <= 1'b1;
          byte_dropped_r <= 1'b0;
        end
        default: begin
          msg_type_r     <= type_r;
          data_byte_r    <= rd_data_r;
          data_valid_r   <= 1'b1;
          frame_last_r   <= stat.idx_last;
          byte_dropped_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_msg_type     = msg_type_r;
  assign out_data_byte    = data_byte_r;
  assign out_data_valid   = data_valid_r;
  assign out_frame_last   = frame_last_r;
  assign out_byte_dropped = byte_dropped_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(BUFFER_DEPTH))
    else $error("held count beyond buffer depth");

  a_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= held_r)
    else $error("scan offset beyond held bytes");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over a stalled result");

endmodule

FILE: rtl/core/header_length_trailer_deframer.sv
// Top level of the header/length/trailer deframer.
// Depends on hltd_pkg, hltd_ctrl and hltd_dp.
//
// Each received byte is stored in a ring of BUFFER_DEPTH bytes and the held bytes
// are scanned for frames: head mark (2 bytes, high first), type, length L, L payload
// bytes, end mark (2 bytes, high first). Bytes ahead of a head mark are dropped one
// at a time; an over-limit length or a missing end mark drops only the first head
// byte and rescans from the next one. A good frame yields one transfer per payload
// byte with its type, frame_last on the last one; an empty frame yields one transfer
// with data_valid low. A byte that arrives with the ring full is not stored and
// yields a transfer with byte_dropped set. Timing: in_stall is low only while the
// sequencer idles, so a new byte is taken only once the scan that the last one
// triggered has finished; the scan runs on the single ring read port, one access
// per step, and waits on any output stall. Configuration is always ready and is
// to be written only while idle.
module header_length_trailer_deframer #(
  parameter int BUFFER_DEPTH = hltd_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_PAYLOAD  = hltd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_msg_type,
  output logic [7:0]  out_data_byte,
  output logic        out_data_valid,
  output logic        out_frame_last,
  output logic        out_byte_dropped
);
  import hltd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: owns the parse phase and issues one ring access per step
  hltd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: ring, pointers, mark compares and the output register
  hltd_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_rx_byte       (in_rx_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_msg_type     (out_msg_type),
    .out_data_byte    (out_data_byte),
    .out_data_valid   (out_data_valid),
    .out_frame_last   (out_frame_last),
    .out_byte_dropped (out_byte_dropped)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for header_length_trailer_deframer.
// Depends on hltd_pkg and the deframer RTL; predicts every transfer on the result channel.
module testbench;
  import hltd_pkg::*;

  localparam int DEPTH = 64;
  localparam int PAYLOAD_CAP = 32;
  localparam int ROOM = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] msg_type;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       frame_last;
    logic       byte_dropped;
  } frag_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_msg_type, out_data_byte;
  logic out_data_valid, out_frame_last, out_byte_dropped;

  header_length_trailer_deframer u_dut (.*);

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: a private mirror of the deframer.
  logic [7:0] ring [DEPTH];
  int unsigned oldest, scan, held, frm_len;
  phase_t phase;
  logic [7:0] frm_type;
  logic [15:0] hd_mark, tl_mark;
  logic [5:0] len_cap;

  logic [7:0] byte_queue[$];
  frag_t      frag_queue[$];
  int         errors = 0;
  int         send_idle_pct = 0, recv_idle_pct = 0;
  bit         hold_off = 1'b0;
  int         quiet = 0;
  logic       in_taken = 1'b0;

  function automatic logic [7:0] peek(int unsigned off);
    return ring[(oldest + off) % DEPTH];
  endfunction

  function automatic void drop_front(int unsigned n);
    oldest = (oldest + n) % DEPTH;
    held -= n;
    scan = oldest;
  endfunction

  function automatic void push_frag(logic [7:0] t, logic [7:0] d, logic v, logic l,
                                    logic dr);
    frag_t f;
    f.msg_type = t; f.data_byte = d; f.data_valid = v; f.frame_last = l;
    f.byte_dropped = dr;
    frag_queue.push_back(f);
  endfunction

  // Work out every transfer that one accepted byte causes.
  function automatic void deframe_byte(logic [7:0] b);
    int n;
    int unsigned off, avail, lim, need, ln;
    bit run;
    n = 0;
    run = 1;
    if (held >= DEPTH) begin
      push_frag(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
      n++;
    end else begin
      ring[(oldest + held) % DEPTH] = b;
      held++;
    end
    lim = len_cap;
    if (lim > PAYLOAD_CAP) lim = PAYLOAD_CAP;
    if (lim > DEPTH - 6) lim = DEPTH - 6;
    while (run) begin
      off = (scan + DEPTH - oldest) % DEPTH;
      avail = held - off;
      case (phase)
        PH_HEAD: begin
          if (avail < 2) run = 0;
          else if (peek(0) == hd_mark[15:8] && peek(1) == hd_mark[7:0]) begin
            scan = (oldest + 2) % DEPTH;
            phase = PH_TYPE;
          end else drop_front(1);
        end
        PH_TYPE: begin
          if (avail < 1) run = 0;
          else begin
            frm_type = peek(off);
            scan = (scan + 1) % DEPTH;
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (avail < 1) run = 0;
          else if (peek(off) > lim) begin
            drop_front(1);
            phase = PH_HEAD;
          end else begin
            frm_len = peek(off);
            scan = (scan + 1) % DEPTH;
            phase = PH_END;
          end
        end
        default: begin
          ln = frm_len;
          need = (ln == 0) ? 1 : ln;
          if (avail < ln + 2) run = 0;
          else if (peek(off + ln) == tl_mark[15:8] && peek(off + ln + 1) == tl_mark[7:0])
              begin
            if (ROOM - n < need) run = 0;
            else begin
              if (ln == 0) begin
                push_frag(frm_type, 8'h00, 1'b0, 1'b1, 1'b0);
                n++;
              end else begin
                for (int i = 0; i < ln; i++) begin
                  push_frag(frm_type, peek(off + i), 1'b1, (i + 1 == ln), 1'b0);
                  n++;
                end
              end
              drop_front(off + ln + 2);
              phase = PH_HEAD;
            end
          end else begin
            drop_front(1);
            phase = PH_HEAD;
          end
        end
      endcase
    end
  endfunction

  // Driver: present queued bytes at the falling edge; hold until transferred.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_rx_byte <= 8'($urandom_range(255));
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: sample transfers at the rising edge, predict and compare.
  always @(posedge clk) begin
    frag_t got, want;
    bit took_in, took_out;
    if (rst_n) begin
      took_in = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      in_taken <= took_in;
      quiet <= (took_in || took_out) ? 0 : quiet + 1;
      if (took_in) begin
        deframe_byte(in_rx_byte);
      end
      if (took_out) begin
        got = {out_msg_type, out_data_byte, out_data_valid, out_frame_last,
               out_byte_dropped};
        if (frag_queue.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = frag_queue.pop_front();
          if (got.msg_type !== want.msg_type)
            $display("%0t: msg_type expected %h actual %h", $time, want.msg_type,
                     got.msg_type);
          if (got.data_byte !== want.data_byte)
            $display("%0t: data_byte expected %h actual %h", $time, want.data_byte,
                     got.data_byte);
          if (got.data_valid !== want.data_valid)
            $display("%0t: data_valid expected %b actual %b", $time, want.data_valid,
                     got.data_valid);
          if (got.frame_last !== want.frame_last)
            $display("%0t: frame_last expected %b actual %b", $time, want.frame_last,
                     got.frame_last);
          if (got.byte_dropped !== want.byte_dropped)
            $display("%0t: byte_dropped expected %b actual %b", $time,
                     want.byte_dropped, got.byte_dropped);
          if (got !== want) errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Write one register at the falling edge and wait for the transfer.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_HEAD_MARK: hd_mark = val;
      REG_END_MARK:  tl_mark = val;
      REG_MAX_LEN:   len_cap = val[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until the byte queue is drained, every prediction has arrived
  // and the deframer has gone back to idle.
  task automatic drain();
    while (byte_queue.size() > 0 || in_valid || frag_queue.size() > 0) @(posedge clk);
    @(negedge clk);
    while (in_stall) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_frame(logic [7:0] t, int unsigned ln, bit good_tail);
    byte_queue.push_back(hd_mark[15:8]);
    byte_queue.push_back(hd_mark[7:0]);
    byte_queue.push_back(t);
    byte_queue.push_back(ln[7:0]);
    for (int i = 0; i < ln; i++) byte_queue.push_back(8'($urandom_range(255)));
    byte_queue.push_back(good_tail ? tl_mark[15:8] : ~tl_mark[15:8]);
    byte_queue.push_back(tl_mark[7:0]);
  endtask

  // Random traffic: mostly good frames, some noise, broken tails and bad lengths.
  task automatic add_random(int count);
    int r;
    int lim;
    int unsigned ln;
    lim = (len_cap > PAYLOAD_CAP) ? PAYLOAD_CAP : len_cap;
    while (count > 0) begin
      r = $urandom_range(99);
      if (r < 65) begin
        ln = ($urandom_range(3) == 0) ? $urandom_range(lim) :
             $urandom_range((lim < 6) ? lim : 6);
        add_frame(8'($urandom_range(255)), ln, 1);
        count -= ln + 6;
      end else if (r < 75) begin
        ln = $urandom_range(lim);
        add_frame(8'($urandom_range(255)), ln, 0);
        count -= ln + 6;
      end else if (r < 82) begin
        byte_queue.push_back(hd_mark[15:8]);
        byte_queue.push_back(hd_mark[7:0]);
        byte_queue.push_back(8'($urandom_range(255)));
        byte_queue.push_back(8'(lim + 1 + $urandom_range(255 - lim - 1)));
        count -= 4;
      end else begin
        byte_queue.push_back(8'($urandom_range(255)));
        count -= 1;
      end
    end
  endtask

  initial begin
    hd_mark = HEAD_MARK_RST;
    tl_mark = END_MARK_RST;
    len_cap = MAX_LEN_RST;
    oldest = 0; scan = 0; held = 0; phase = PH_HEAD; frm_type = '0; frm_len = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty frame, longest frame, over-limit length, broken tail, extremes.
    add_frame(8'h00, 0, 1);
    add_frame(8'hFF, 32, 1);
    byte_queue.push_back(8'hA5); byte_queue.push_back(8'h5A);
    byte_queue.push_back(8'h11); byte_queue.push_back(8'd33);
    add_frame(8'h5A, 1, 0);
    byte_queue.push_back(8'h00); byte_queue.push_back(8'hFF);
    add_frame(8'h81, 1, 1);
    drain();

    // Hold the receiver off so the results back up and the input stalls.
    hold_off = 1'b1;
    add_frame(8'h3C, 32, 1);
    add_frame(8'hC3, 32, 1);
    for (int i = 0; i < 40; i++) byte_queue.push_back(8'h00);
    repeat (1500) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // Phase one: sender idles less, receiver more.
    send_idle_pct = 23; recv_idle_pct = 58;
    write_reg(REG_HEAD_MARK, 16'h0000);
    write_reg(REG_END_MARK, 16'hFFFF);
    write_reg(REG_MAX_LEN, 16'd0);
    add_random(35);
    drain();
    write_reg(REG_MAX_LEN, 16'd63);
    write_reg(REG_HEAD_MARK, 16'hFFFF);
    write_reg(REG_END_MARK, 16'h0000);
    add_random(35);
    drain();

    // Phase two: the other way round.
    send_idle_pct = 58; recv_idle_pct = 23;
    write_reg(REG_HEAD_MARK, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_END_MARK, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_MAX_LEN, 16'($urandom_range(1, 31)));
    add_random(40);
    drain();

    // Phase three: no idling, reset-value marks.
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_HEAD_MARK, HEAD_MARK_RST);
    write_reg(REG_END_MARK, END_MARK_RST);
    write_reg(REG_MAX_LEN, 16'd32);
    add_random(40);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
